[rtl/core/sfd_pkg.sv]
// Shared types and constants for the serial feedback deframer.
package sfd_pkg;

  localparam int unsigned FRAME_BYTES = 18;
  localparam int unsigned NUM_WORDS   = FRAME_BYTES / 2;
  localparam int unsigned SUM_WORDS   = NUM_WORDS - 1;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_IDLE  = pos_t'(0);
  localparam pos_t POS_FIRST = pos_t'(2);
  localparam pos_t POS_LAST  = pos_t'(FRAME_BYTES - 1);

  localparam logic [15:0] START_RESET = 16'hABCD;

  typedef struct packed {
    logic               frame_ok;
    logic signed [15:0] command_one;
    logic signed [15:0] command_two;
    logic signed [15:0] speed_right;
    logic signed [15:0] speed_left;
    logic signed [15:0] battery_voltage;
    logic signed [15:0] board_temperature;
    logic        [15:0] led_command;
  } result_t;

endpackage

[rtl/core/sfd_input_reg.sv]
// Input register stage for received bytes.
module sfd_input_reg
  import sfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       byte_valid,
  input  logic       byte_ready,
  output logic [7:0] byte_data
);

  logic       held;
  logic [7:0] held_byte;

  assign in_ready   = !held || byte_ready;
  assign byte_valid = held;
  assign byte_data  = held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

[rtl/core/sfd_frame_engine.sv]
// Start word search, frame store, checksum and result register.
module sfd_frame_engine
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] start_word,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  byte_data,
  output logic        res_valid,
  input  logic        res_ready,
  output result_t     res
);

  logic [7:0]  previous_byte;
  pos_t        byte_position;
  pos_t        byte_position_next;
  logic [7:0]  frame_store [FRAME_BYTES];
  logic [15:0] word [NUM_WORDS];
  logic [15:0] sum;
  logic        take;
  logic        start_hit;
  logic        complete;
  logic        ok;
  result_t     res_next;

  assign byte_ready = !res_valid || res_ready;
  assign take       = byte_valid && byte_ready;
  assign start_hit  = {byte_data, previous_byte} == start_word;
  assign complete   = take && !start_hit && (byte_position == POS_LAST);

  always_comb begin
    byte_position_next = byte_position;
    if (start_hit) begin
      byte_position_next = POS_FIRST;
    end else if (byte_position == POS_LAST) begin
      byte_position_next = POS_IDLE;
    end else if (byte_position != POS_IDLE) begin
      byte_position_next = byte_position + pos_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte <= 8'd0;
      byte_position <= POS_IDLE;
    end else if (take) begin
      previous_byte <= byte_data;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (start_hit) begin
        frame_store[0] <= previous_byte;
        frame_store[1] <= byte_data;
      end else if (byte_position != POS_IDLE) begin
        frame_store[byte_position] <= byte_data;
      end
    end
  end

  // last byte of the frame comes straight from the input, not the store
  always_comb begin
    for (int i = 0; i < SUM_WORDS; i++) begin
      word[i] = {frame_store[2*i+1], frame_store[2*i]};
    end
    word[SUM_WORDS] = {byte_data, frame_store[FRAME_BYTES-2]};
  end

  always_comb begin
    sum = 16'd0;
    for (int i = 0; i < SUM_WORDS; i++) begin
      sum = sum ^ word[i];
    end
  end

  assign ok = (word[0] == start_word) && (sum == word[SUM_WORDS]);

  always_comb begin
    res_next                   = '0;
    res_next.frame_ok          = ok;
    if (ok) begin
      res_next.command_one       = word[1];
      res_next.command_two       = word[2];
      res_next.speed_right       = word[3];
      res_next.speed_left        = word[4];
      res_next.battery_voltage   = word[5];
      res_next.board_temperature = word[6];
      res_next.led_command       = word[7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (complete) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_LAST)
    else $error("byte position beyond frame");

  a_pos_not_one: assert property (@(posedge clk) disable iff (rst)
    byte_position != pos_t'(1))
    else $error("byte position stuck between start bytes");

  a_start_restart: assert property (@(posedge clk) disable iff (rst)
    take && start_hit |=> byte_position == POS_FIRST)
    else $error("start word did not restart frame");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("stalled result lost or changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !take)
    else $error("byte taken while result stalled");
`endif

endmodule

[rtl/core/serial_feedback_deframer_core.sv]
// Top level of the serial feedback deframer.
//
//  channel  dir  handshake              payload
//  in       in   in_valid / in_ready    rx_byte
//  out      out  out_valid / out_ready  frame_ok and seven frame words
//  cfg      in   cfg_we                 cfg_data (start word)
//
// One byte per cycle while no result is stalled; a byte passes the input
// register and then the frame engine, whose result register loads, raising
// out_valid, as the engine takes the byte that completes a frame.
// rst is synchronous: start word returns to 0xABCD, no frame in progress.
// A result waiting on out_ready stalls byte processing; one byte still
// lands in the input register, and in_ready drops after that.
module serial_feedback_deframer_core
  import sfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               frame_ok,
  output logic signed [15:0] command_one,
  output logic signed [15:0] command_two,
  output logic signed [15:0] speed_right,
  output logic signed [15:0] speed_left,
  output logic signed [15:0] battery_voltage,
  output logic signed [15:0] board_temperature,
  output logic        [15:0] led_command,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data
);

  logic [15:0] start_word;
  logic        byte_valid;
  logic        byte_ready;
  logic [7:0]  byte_data;
  result_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_word <= START_RESET;
    end else if (cfg_we) begin
      start_word <= cfg_data;
    end
  end

  sfd_input_reg u_input_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data)
  );

  sfd_frame_engine u_frame_engine (
    .clk        (clk),
    .rst        (rst),
    .start_word (start_word),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign frame_ok          = res.frame_ok;
  assign command_one       = res.command_one;
  assign command_two       = res.command_two;
  assign speed_right       = res.speed_right;
  assign speed_left        = res.speed_left;
  assign battery_voltage   = res.battery_voltage;
  assign board_temperature = res.board_temperature;
  assign led_command       = res.led_command;

endmodule
